// ===== rtl/dac_waveform_generator_macros.svh =====
// Assertion helpers shared by the generator RTL.
// Each expects clk and arst_n in scope.
`ifndef DAC_WAVEFORM_GENERATOR_MACROS_SVH
`define DAC_WAVEFORM_GENERATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define DWG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dwg_pkg.sv =====
package dwg_pkg;

	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 8;
	localparam int DAC_BITS_DEF        = 12;
	localparam int QUEUE_DEPTH         = 2;

	localparam int SAMPLE_W  = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_WORD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd4;

	localparam logic [1:0] MODE_FLAT   = 2'd0;
	localparam logic [1:0] MODE_SQUARE = 2'd1;
	localparam logic [1:0] MODE_SINE   = 2'd2;

	localparam logic [11:0] FULL_SCALE_RST = 12'd4095;

	typedef struct packed {
		logic [1:0]         wave_mode;
		logic [31:0]        freq_word;
		logic [15:0]        amplitude;
		logic signed [15:0] offset;
		logic [11:0]        full_scale;
	} cfg_t;

endpackage

// ===== rtl/dwg_fifo.sv =====
module dwg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dwg_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = push && !full;
	assign do_rd   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`include "dac_waveform_generator_macros.svh"

	`DWG_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/dwg_front.sv =====
module dwg_front #(
	parameter int PHASE_BITS      = dwg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = dwg_pkg::SINE_TABLE_BITS_DEF,
	parameter int DEPTH           = dwg_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         restart,
	output logic                         full,
	input  logic [31:0]                  freq_word,
	input  logic                         cmd_pop,
	output logic                         cmd_empty,
	output logic [SINE_TABLE_BITS+1:0]   cmd_lev
);

	localparam int LEV_BITS = SINE_TABLE_BITS + 2;

	logic [PHASE_BITS-1:0]    phase_q;
	logic [PHASE_BITS-1:0]    ph_cur;
	logic [PHASE_BITS-1:0]    step;
	logic [PHASE_BITS+31:0]   step_wide;
	logic                     accept;

	// freq_word scaled to the accumulator width: times 2^(PHASE_BITS-32)
	assign step_wide = {freq_word, PHASE_BITS'(0)};
	assign step      = step_wide[PHASE_BITS+31:32];
	assign ph_cur    = restart ? '0 : phase_q;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= ph_cur + step;
		end
	end

	// only the quadrant and table index travel to the back end
	dwg_fifo #(
		.WIDTH (LEV_BITS),
		.DEPTH (DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (ph_cur[PHASE_BITS-1 -: LEV_BITS]),
		.full    (full),
		.pop     (cmd_pop),
		.rd_data (cmd_lev),
		.empty   (cmd_empty)
	);

`include "dac_waveform_generator_macros.svh"

	`DWG_ASSERT_NEXT(a_restart_phase, accept && restart, phase_q == $past(step), "restart did not clear phase")

endmodule

// ===== rtl/dwg_back.sv =====
module dwg_back #(
	parameter int SINE_TABLE_BITS = dwg_pkg::SINE_TABLE_BITS_DEF,
	parameter int DAC_BITS        = dwg_pkg::DAC_BITS_DEF,
	parameter int DEPTH           = dwg_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dwg_pkg::cfg_t                      cfg,
	input  logic                               cmd_empty,
	input  logic [SINE_TABLE_BITS+1:0]         cmd_lev,
	output logic                               cmd_pop,
	output logic                               empty,
	input  logic                               pop,
	output logic [dwg_pkg::SAMPLE_W-1:0]       sample
);

	localparam int QSIZE   = 1 << SINE_TABLE_BITS;
	localparam int ADDR_W  = SINE_TABLE_BITS + 1;
	localparam int DAC_MAX = (1 << DAC_BITS) - 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LEVEL = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;

	typedef logic [15:0] rom_t [QSIZE+1];

	// quarter-wave sine, Q15, Taylor series through x^13 in Q30
	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		for (int k = 0; k < QSIZE; k++) begin
			x    = (64'(k) * dwg_pkg::HALF_PI_Q30) >> SINE_TABLE_BITS;
			term = x;
			sum  = x;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				case (n)
					1:       term = term / 64'd6;
					2:       term = term / 64'd20;
					3:       term = term / 64'd42;
					4:       term = term / 64'd72;
					5:       term = term / 64'd110;
					default: term = term / 64'd156;
				endcase
				if (n[0]) begin
					sum = (sum >= term) ? sum - term : 64'd0;
				end else begin
					sum = sum + term;
				end
			end
			r = (sum + 64'd16384) >> 15;
			if (r > 64'd32768) begin
				r = 64'd32768;
			end
			rom[k] = 16'(r);
		end
		rom[QSIZE] = 16'd32768;
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [1:0]                      st_q;
	logic                            start;
	logic                            out_push;
	logic                            out_full;

	logic [1:0]                      quad;
	logic [SINE_TABLE_BITS-1:0]      idx;
	logic [ADDR_W-1:0]               addr;
	logic [15:0]                     amp_sat;
	logic signed [17:0]              off_w;
	logic signed [17:0]              amp_w;
	logic signed [17:0]              off_cl;

	logic [15:0]                     rom_s1;
	logic                            neg_s1;
	logic [15:0]                     amp_s1;
	logic signed [16:0]              off_s1;

	logic signed [33:0]              lev_v;
	logic signed [33:0]              amp_e;
	logic signed [33:0]              off_e;
	logic signed [33:0]              n_w;
	logic [31:0]                     n_cl;
	logic [31:0]                     n_s2;

	logic [11:0]                     scale_w;
	logic [43:0]                     prod;
	logic [dwg_pkg::SAMPLE_W-1:0]    code;

	// front of the queue: table address and offset clamp
	assign quad    = cmd_lev[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
	assign idx     = cmd_lev[SINE_TABLE_BITS-1:0];
	assign addr    = quad[0] ? (ADDR_W'(QSIZE) - {1'b0, idx}) : {1'b0, idx};
	assign amp_sat = (cfg.amplitude > 16'd32768) ? 16'd32768 : cfg.amplitude;
	assign off_w   = 18'(cfg.offset);
	assign amp_w   = {2'b00, amp_sat};

	always_comb begin
		if (off_w + amp_w > 18'sd32768) begin
			off_cl = 18'sd32768 - amp_w;
		end else if (off_w - amp_w < -18'sd32768) begin
			off_cl = amp_w - 18'sd32768;
		end else begin
			off_cl = off_w;
		end
	end

	// level stage: N = amp*level + off*2^15 + 2^30, clamped to 0..2^31
	always_comb begin
		unique case (cfg.wave_mode)
			dwg_pkg::MODE_SQUARE: lev_v = neg_s1 ? -34'sd32768 : 34'sd32768;
			dwg_pkg::MODE_SINE:   lev_v = neg_s1 ? -$signed({18'd0, rom_s1})
			                                     : $signed({18'd0, rom_s1});
			default:              lev_v = '0;
		endcase
	end

	assign amp_e = $signed({18'd0, amp_s1});
	assign off_e = 34'(off_s1);
	assign n_w   = amp_e * lev_v + (off_e <<< 15) + 34'sd1073741824;

	always_comb begin
		if (n_w < 0) begin
			n_cl = '0;
		end else if (n_w > 34'sd2147483648) begin
			n_cl = 32'h8000_0000;
		end else begin
			n_cl = n_w[31:0];
		end
	end

	// scale stage; N <= 2^31 keeps the code within 0..scale
	assign scale_w = (32'(cfg.full_scale) > DAC_MAX) ? 12'(DAC_MAX) : cfg.full_scale;
	assign prod    = {12'd0, n_s2} * {32'd0, scale_w};
	assign code    = prod[42:31];

	assign start    = !cmd_empty &&
	                  (((st_q == ST_IDLE) && !out_full) || ((st_q == ST_SCALE) && empty));
	assign cmd_pop  = start;
	assign out_push = (st_q == ST_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE:  st_q <= start ? ST_LEVEL : ST_IDLE;
				ST_LEVEL: st_q <= ST_SCALE;
				ST_SCALE: st_q <= start ? ST_LEVEL : ST_IDLE;
				default:  st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rom_s1 <= SINE_ROM[addr];
			neg_s1 <= quad[1];
			amp_s1 <= amp_sat;
			off_s1 <= off_cl[16:0];
		end
		if (st_q == ST_LEVEL) begin
			n_s2 <= n_cl;
		end
	end

	dwg_fifo #(
		.WIDTH (dwg_pkg::SAMPLE_W),
		.DEPTH (DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (code),
		.full    (out_full),
		.pop     (pop),
		.rd_data (sample),
		.empty   (empty)
	);

`include "dac_waveform_generator_macros.svh"

	`DWG_ASSERT_NOW(a_out_room, out_push, !out_full, "result beat lost on full queue")
	`DWG_ASSERT_NOW(a_code_range, out_push, code <= scale_w, "code above scale")

endmodule

// ===== rtl/dac_waveform_generator.sv =====
// The back end's level then scale stages (one multiply each) are shared by all samples;
// a new beat enters the level stage while the last one is in the scale stage only if
// the result queue is empty, else only once the last one has left the scale stage.
// Reset (arst_n low, asynchronous): phase to zero, queues empty, registers to
// flat mode, zero frequency, amplitude and offset, full scale 4095.
module dac_waveform_generator #(
	parameter int PHASE_BITS      = dwg_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = dwg_pkg::SINE_TABLE_BITS_DEF,
	parameter int DAC_BITS        = dwg_pkg::DAC_BITS_DEF,
	parameter int QUEUE_DEPTH     = dwg_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            restart,
	output logic                            empty,
	input  logic                            pop,
	output logic [dwg_pkg::SAMPLE_W-1:0]    sample,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dwg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dwg_pkg::CFG_DAT_W-1:0]   cfg_data
);

	dwg_pkg::cfg_t                cfg_q;
	logic                         cmd_pop;
	logic                         cmd_empty;
	logic [SINE_TABLE_BITS+1:0]   cmd_lev;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_mode  <= dwg_pkg::MODE_FLAT;
			cfg_q.freq_word  <= '0;
			cfg_q.amplitude  <= '0;
			cfg_q.offset     <= '0;
			cfg_q.full_scale <= dwg_pkg::FULL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dwg_pkg::REG_WAVE_MODE:  cfg_q.wave_mode  <= cfg_data[1:0];
				dwg_pkg::REG_FREQ_WORD:  cfg_q.freq_word  <= cfg_data[31:0];
				dwg_pkg::REG_AMPLITUDE:  cfg_q.amplitude  <= cfg_data[15:0];
				dwg_pkg::REG_OFFSET:     cfg_q.offset     <= $signed(cfg_data[15:0]);
				dwg_pkg::REG_FULL_SCALE: cfg_q.full_scale <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	dwg_front #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.DEPTH           (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.restart   (restart),
		.full      (full),
		.freq_word (cfg_q.freq_word),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd_lev   (cmd_lev)
	);

	dwg_back #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.DAC_BITS        (DAC_BITS),
		.DEPTH           (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd_lev   (cmd_lev),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.sample    (sample)
	);

endmodule
